// ===== src/fqrf_pkg.sv =====
// Shared types and constants for the searchable FIFO queue.
`default_nettype none

package fqrf_pkg;

	localparam int ITEM_W = 32;
	localparam int CMD_W  = 2;
	localparam int POS_W  = 5;
	localparam int STS_W  = 3;
	localparam int CNT_W  = 5;

	localparam logic [POS_W-1:0] POS_NONE = '1;
	localparam logic [POS_W-1:0] POS_ZERO = '0;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_TAKE   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 3'd0,
		STS_EMPTY     = 3'd1,
		STS_FULL      = 3'd2,
		STS_NULL      = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    start;      // input transfer: latch command and item
		logic    wr_append;  // write item at the tail, bump count
		logic    run;        // issue entry reads while any remain
		logic    hit;        // record match position and taken item
		logic    miss;       // record not-found result
		logic    shift;      // write read data one place toward the head
		logic    dec;        // drop one from the count
		logic    emit;       // load the output register
		status_t res_status; // status to set on start
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		cmd_t in_cmd;    // command on the input channel
		logic in_null;   // item on the input channel is null
		cmd_t cmd_q;     // latched command
		logic empty;
		logic full;
		logic match;     // read data valid and matching
		logic last;      // read data valid and from the last entry
		logic pending;   // reads left to issue or one in flight
		logic out_free;  // output register can take a result
	} sts_t;

endpackage

`default_nettype wire

// ===== src/fqrf_req_if.sv =====
// Command channel: valid/ready handshake with command and item payload.
`default_nettype none

interface fqrf_req_if;
	logic                            valid;
	logic                            ready;
	logic [fqrf_pkg::CMD_W-1:0]      cmd;
	logic [fqrf_pkg::ITEM_W-1:0]     item;

	modport source (output valid, output cmd, output item, input ready);
	modport sink   (input valid, input cmd, input item, output ready);
endinterface

`default_nettype wire

// ===== src/fqrf_rsp_if.sv =====
// Result channel: valid/ready handshake with the per-command result payload.
`default_nettype none

interface fqrf_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [fqrf_pkg::ITEM_W-1:0]        item_out;
	logic signed [fqrf_pkg::POS_W-1:0]  position;
	logic [fqrf_pkg::STS_W-1:0]         status;
	logic [fqrf_pkg::CNT_W-1:0]         count;
	logic                               is_empty;

	modport source (output valid, output item_out, output position, output status,
		output count, output is_empty, input ready);
	modport sink   (input valid, input item_out, input position, input status,
		input count, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== src/fqrf_ctrl.sv =====
// Controller state machine sequencing append, take, remove and find.
`default_nettype none

module fqrf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire fqrf_pkg::sts_t sts,
	output fqrf_pkg::ctl_t     ctl
);
	import fqrf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode state and status into datapath commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		ctl            = '0;
		ctl.res_status = STS_OK;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.start = 1'b1;
					unique case (sts.in_cmd) inside
						CMD_APPEND: begin
							state_d = S_RESP;
							if (sts.in_null) begin
								ctl.res_status = STS_NULL;
							end else if (sts.full) begin
								ctl.res_status = STS_FULL;
							end else begin
								ctl.wr_append = 1'b1;
							end
						end
						CMD_TAKE: begin
							if (sts.empty) begin
								ctl.res_status = STS_EMPTY;
								state_d        = S_RESP;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_REMOVE, CMD_FIND: begin
							if (sts.in_null || sts.empty) begin
								ctl.res_status = STS_NOT_FOUND;
								state_d        = S_RESP;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				ctl.run = 1'b1;
				if (sts.match) begin
					ctl.hit = 1'b1;
					state_d = (sts.cmd_q == CMD_FIND) ? S_RESP : S_SHIFT;
				end else if (sts.last) begin
					ctl.miss = 1'b1;
					state_d  = S_RESP;
				end
			end
			S_SHIFT: begin
				ctl.run   = 1'b1;
				ctl.shift = 1'b1;
				if (!sts.pending) begin
					ctl.dec = 1'b1;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/fqrf_dpath.sv =====
// Datapath: entry memory, occupancy, scan pointers and result registers.
`default_nettype none

module fqrf_dpath #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [fqrf_pkg::CMD_W-1:0]    in_cmd,
	input  wire logic [fqrf_pkg::ITEM_W-1:0]   in_item,
	input  wire fqrf_pkg::ctl_t                ctl,
	output fqrf_pkg::sts_t                     sts,
	fqrf_rsp_if.source                         rsp
);
	import fqrf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [ITEM_W-1:0] mem [DEPTH];

	cmd_t              cmd_q;
	logic [ITEM_W-1:0] item_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ip_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic [ITEM_W-1:0] rdata_s1;

	logic [ITEM_W-1:0] res_item_q;
	logic [POS_W-1:0]  res_pos_q;
	status_t           res_status_q;

	logic              ovalid_q;
	logic [ITEM_W-1:0] o_item_q;
	logic [POS_W-1:0]  o_pos_q;
	logic [STS_W-1:0]  o_status_q;
	logic [CNT_W-1:0]  o_count_q;
	logic              o_empty_q;

	logic              issue;
	logic              more;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [ITEM_W-1:0] wdata;

	// Read and write control
	assign more  = ip_q < count_q;
	assign issue = ctl.run && more;
	assign we    = ctl.wr_append || (ctl.shift && rd_vld_s1);
	assign waddr = ctl.wr_append ? count_q[AW-1:0] : (rd_idx_s1 - AW'(1));
	assign wdata = ctl.wr_append ? in_item : rdata_s1;

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rdata_s1  <= mem[ip_q[AW-1:0]];
			rd_idx_s1 <= ip_q[AW-1:0];
		end
	end

	// Track read pointer and read data valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q      <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (ctl.start) begin
			ip_q      <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				ip_q <= ip_q + CW'(1);
			end
		end
	end

	// Update occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.wr_append) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Latch command and build the result
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q        <= cmd_t'(in_cmd);
			item_q       <= in_item;
			res_item_q   <= '0;
			res_status_q <= ctl.res_status;
			res_pos_q    <= (ctl.res_status == STS_NOT_FOUND) ? POS_NONE : POS_ZERO;
		end else if (ctl.hit) begin
			res_pos_q  <= POS_W'(rd_idx_s1);
			res_item_q <= (cmd_q == CMD_TAKE) ? rdata_s1 : '0;
		end else if (ctl.miss) begin
			res_status_q <= STS_NOT_FOUND;
			res_pos_q    <= POS_NONE;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctl.emit) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			o_item_q   <= res_item_q;
			o_pos_q    <= res_pos_q;
			o_status_q <= res_status_q;
			o_count_q  <= CNT_W'(count_q);
			o_empty_q  <= (count_q == '0);
		end
	end

	assign rsp.valid    = ovalid_q;
	assign rsp.item_out = o_item_q;
	assign rsp.position = o_pos_q;
	assign rsp.status   = o_status_q;
	assign rsp.count    = o_count_q;
	assign rsp.is_empty = o_empty_q;

	// Report status to the controller
	always_comb begin
		sts          = '0;
		sts.in_cmd   = cmd_t'(in_cmd);
		sts.in_null  = (in_item == '0);
		sts.cmd_q    = cmd_q;
		sts.empty    = (count_q == '0);
		sts.full     = (count_q == CW'(DEPTH));
		sts.match    = rd_vld_s1 && ((cmd_q == CMD_TAKE) || (rdata_s1 == item_q));
		sts.last     = rd_vld_s1 && ((CW'(rd_idx_s1) + CW'(1)) == count_q);
		sts.pending  = more || rd_vld_s1;
		sts.out_free = !ovalid_q || rsp.ready;
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_append |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not grow occupancy");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!ovalid_q || rsp.ready))
		else $error("result overwrote an untaken result");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.shift && rd_vld_s1) |-> rd_idx_s1 != '0)
		else $error("gap close wrote before the head");
`endif

endmodule

`default_nettype wire

// ===== src/fifo_queue_with_remove_and_find.sv =====
// Top level of the bounded FIFO queue with remove-by-value and find.
`default_nettype none

// Bounded FIFO of DEPTH nonzero 32-bit handles, one command at a time: append,
// take head, remove first match (later entries move up) or find position.
// Each command returns exactly one result with status, count and empty flag.
// Append and the errors found without a walk (null item, full queue, empty
// queue) go straight to the result; find stops at the first match, while a
// miss walks every entry and take and remove walk on to the tail, since the
// entries are walked through a memory with one read port and one write
// port, one entry per cycle.
// A new command is taken once the previous result sits in the output
// register, even before that result is transferred.
module fifo_queue_with_remove_and_find #(
	parameter int DEPTH = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fqrf_req_if.sink    req,
	fqrf_rsp_if.source  rsp
);
	import fqrf_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic ready;

	assign req.ready = ready;

	fqrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	fqrf_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_cmd  (req.cmd),
		.in_item (req.item),
		.ctl     (ctl),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
